// ===== hdl/ohlc_bar_aggregator_defines.svh =====
// Assertion macros for the OHLC bar aggregator
`ifndef OHLC_BAR_AGGREGATOR_DEFINES_SVH
`define OHLC_BAR_AGGREGATOR_DEFINES_SVH
// check that a condition implies a consequence on the same edge
`define OHLC_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("ohlc check failed");
// check that a condition implies a consequence on the next edge
`define OHLC_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("ohlc check failed");
`endif

// ===== hdl/ohlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared constants and types for the OHLC bar aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;
  localparam int unsigned NumSymbolsDef = 64;
  localparam logic [30:0] VolMax = 31'h7FFF_FFFF;
  localparam logic [62:0] ToMax  = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [16:0] MsPerMin = 17'd60000;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FLUSH = 2'd1
  } func_e;

  // one stored bar
  typedef struct packed {
    logic [26:0] start_ms;
    logic [31:0] open_p;
    logic [31:0] high_p;
    logic [31:0] low_p;
    logic [31:0] close_p;
    logic [30:0] vol;
    logic [62:0] to;
    logic [30:0] prev_vol;
    logic [62:0] prev_to;
  } bar_t;

  // divider control and status
  typedef struct packed {
    logic        start;
    logic [26:0] dividend;
    logic [27:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [26:0] quotient;
  } div_rsp_t;
endpackage

// ===== hdl/ohlc_div.sv =====
// ----------------------------------------------------------------------------
// ohlc_div
// Restoring divider, one quotient bit a cycle, 27 quotient bits.
// ----------------------------------------------------------------------------
module ohlc_div
  import ohlc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [27:0] rem_q, rem_d;
  logic [26:0] quo_q, quo_d;
  logic [27:0] div_q, div_d;
  logic [28:0] trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[26]} - {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial[28]) begin
        rem_d = {rem_q[26:0], quo_q[26]};
        quo_d = {quo_q[25:0], 1'b0};
      end else begin
        rem_d = trial[27:0];
        quo_d = {quo_q[25:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd26) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == 5'd26);
  assign rsp_o.quotient = {quo_q[25:0], ~trial[28]};
endmodule

// ===== hdl/ohlc_bar_aggregator.sv =====
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator
// Per-symbol OHLCV time bar builder with flush of all open bars.
// ----------------------------------------------------------------------------
// Usage: drive func_i and the tick fields with start_i high while busy_o is
// low; the word is taken at that edge and busy_o rises, unless a tick names
// a symbol at or beyond NUM_SYMBOLS. A tick decodes its HHMMSSmmm time and
// aligns it to the interval with a bit-serial divider. A finished bar
// appears for one cycle on the bar ports with bar_valid_o high. A flush
// walks the symbol store, one entry a cycle, and emits each open bar with
// last_of_run_o on the last one. The receiver cannot stall: results are
// shown exactly once. interval_minutes is written over the APB port at byte
// address 0; the user must do so only while the block is idle, which the
// block itself does not enforce. Reset clears all open flags and sets the
// interval to one minute; the bar store itself is not cleared.
// ----------------------------------------------------------------------------
`include "ohlc_bar_aggregator_defines.svh"
module ohlc_bar_aggregator
  import ohlc_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS = NumSymbolsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [5:0]  symbol_index_i,
  input  logic [27:0] time_of_day_i,
  input  logic [31:0] price_i,
  input  logic [30:0] cum_volume_i,
  input  logic [62:0] cum_turnover_i,
  output logic        bar_valid_o,
  output logic [5:0]  bar_symbol_o,
  output logic [26:0] bar_start_ms_o,
  output logic [31:0] open_price_o,
  output logic [31:0] high_price_o,
  output logic [31:0] low_price_o,
  output logic [31:0] close_price_o,
  output logic [30:0] bar_volume_o,
  output logic [62:0] bar_turnover_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SYMBOLS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_DIVGO = 9'b000000100,
    S_DIVW  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_FRD   = 9'b010000000,
    S_FOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [10:0] ivmin_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = {21'd0, ivmin_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ivmin_q <= 11'd1;
    else if (cfg_wr) ivmin_q <= pwdata[10:0];
  end

  // captured tick word
  logic [IdxW-1:0] sym_q;
  logic [27:0] tod_q;
  logic [31:0] price_q;
  logic [30:0] cvol_q;
  logic [62:0] cto_q;
  logic        sym_ok;
  assign sym_ok = ({26'd0, symbol_index_i} < 32'(NUM_SYMBOLS));

  // bar store and open flags
  bar_t mem [NUM_SYMBOLS];
  bar_t rd_q;
  logic [NUM_SYMBOLS-1:0] open_q;
  logic [IdxW-1:0] raddr;
  logic        we;
  bar_t        wdata;

  // flush walk
  logic [CntW-1:0] fidx_q, fidx_d;
  logic            fvalid_q;

  // timing
  logic [26:0] cur_q, cur_d;
  logic [27:0] iv_q;
  logic [26:0] quo_q;
  logic [26:0] start_q;

  // time decode pieces: digits by constant division
  logic [27:0] hh, mm, ss, ms;
  assign hh = time_of_day_i / 28'd10000000;
  assign mm = (time_of_day_i / 28'd100000) % 28'd100;
  assign ss = (time_of_day_i / 28'd1000) % 28'd100;
  assign ms = time_of_day_i % 28'd1000;
  logic [26:0] hh_q, mm_q, ss_q, ms_q;

  div_req_t dreq;
  div_rsp_t drsp;
  ohlc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign dreq.start    = (state_q == S_DIVGO);
  assign dreq.dividend = cur_q;
  assign dreq.divisor  = iv_q;

  assign raddr = (state_q == S_FRD) ? fidx_q[IdxW-1:0] : sym_q;

  // store write port and read port
  always_ff @(posedge clk_i) begin
    if (we) mem[sym_q] <= wdata;
    rd_q <= mem[raddr];
  end

  // compute the update for a tick
  logic        emit;
  logic [30:0] dv;
  logic [62:0] dt;
  bar_t        base;
  logic [31:0] vsum;
  logic [63:0] tsum;
  always_comb begin
    dv = (cvol_q > rd_q.prev_vol) ? cvol_q - rd_q.prev_vol : 31'd0;
    dt = (cto_q > rd_q.prev_to) ? cto_q - rd_q.prev_to : 63'd0;
    emit = open_q[sym_q] &&
           ({1'b0, cur_q} >= {1'b0, rd_q.start_ms} + iv_q);
    base = rd_q;
    if (emit) begin
      base.start_ms = start_q;
      base.open_p   = price_q;
      base.high_p   = price_q;
      base.low_p    = price_q;
      base.vol      = '0;
      base.to       = '0;
    end
    wdata = base;
    if ($signed(base.high_p) < $signed(price_q)) wdata.high_p = price_q;
    if ($signed(price_q) < $signed(base.low_p)) wdata.low_p = price_q;
    wdata.close_p = price_q;
    vsum = {1'b0, base.vol} + {1'b0, dv};
    tsum = {1'b0, base.to} + {1'b0, dt};
    wdata.vol = vsum[31] ? VolMax : vsum[30:0];
    wdata.to  = tsum[63] ? ToMax : tsum[62:0];
    wdata.prev_vol = cvol_q;
    wdata.prev_to  = cto_q;
    if (!open_q[sym_q]) begin
      wdata.start_ms = start_q;
      wdata.open_p   = price_q;
      wdata.high_p   = price_q;
      wdata.low_p    = price_q;
      wdata.vol      = '0;
      wdata.to       = '0;
    end
  end
  assign we = (state_q == S_UPD);

  // sequencer
  always_comb begin
    state_d = state_q;
    fidx_d  = fidx_q;
    cur_d   = cur_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_FLUSH[0]) begin
            state_d = S_FRD;
            fidx_d  = '0;
          end else if (sym_ok) begin
            state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        cur_d   = 27'(hh_q * 27'd3600000 + mm_q * 27'd60000 +
                      ss_q * 27'd1000 + ms_q);
        state_d = S_DIVGO;
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (drsp.done) state_d = S_MUL;
      S_MUL:   state_d = S_UPD;
      S_UPD:   state_d = S_WRITE;
      S_WRITE: state_d = S_IDLE;
      S_FRD: begin
        if (fidx_q == CntW'(NUM_SYMBOLS)) state_d = S_FOUT;
        else fidx_d = fidx_q + 1'b1;
      end
      S_FOUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // open entries beyond an index, to mark the last open bar of a flush
  logic [NUM_SYMBOLS-1:0] later_mask;
  logic [IdxW-1:0]        prev_idx_q;
  always_comb begin
    later_mask = '0;
    for (int i = 0; i < NUM_SYMBOLS; i++)
      later_mask[i] = (i > int'(prev_idx_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fidx_q      <= '0;
      open_q      <= '0;
      fvalid_q    <= 1'b0;
      bar_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      fidx_q      <= fidx_d;
      bar_valid_o <= 1'b0;
      fvalid_q    <= (state_q == S_FRD) && (fidx_q < CntW'(NUM_SYMBOLS)) &&
                     open_q[fidx_q[IdxW-1:0]];
      if (we) begin
        open_q[sym_q] <= 1'b1;
        bar_valid_o   <= emit;
      end
      if (fvalid_q) bar_valid_o <= 1'b1;
    end
  end

  // datapath registers and result word
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (state_q == S_IDLE) begin
      sym_q   <= symbol_index_i[IdxW-1:0];
      tod_q   <= time_of_day_i;
      price_q <= price_i;
      cvol_q  <= cum_volume_i;
      cto_q   <= cum_turnover_i;
      hh_q <= hh[26:0];
      mm_q <= mm[26:0];
      ss_q <= ss[26:0];
      ms_q <= ms[26:0];
      iv_q <= 28'((ivmin_q == 11'd0 ? 11'd1 : ivmin_q) * MsPerMin);
    end
    if (drsp.done) quo_q <= drsp.quotient;
    if (state_q == S_MUL) start_q <= 27'(quo_q * iv_q);
    if (state_q == S_FRD) prev_idx_q <= fidx_q[IdxW-1:0];
    if (we) begin
      bar_symbol_o   <= 6'(sym_q);
      bar_start_ms_o <= rd_q.start_ms;
      open_price_o   <= rd_q.open_p;
      high_price_o   <= rd_q.high_p;
      low_price_o    <= rd_q.low_p;
      close_price_o  <= rd_q.close_p;
      bar_volume_o   <= rd_q.vol;
      bar_turnover_o <= rd_q.to;
      last_of_run_o  <= 1'b1;
    end
    if (fvalid_q) begin
      bar_symbol_o   <= 6'(prev_idx_q);
      bar_start_ms_o <= rd_q.start_ms;
      open_price_o   <= rd_q.open_p;
      high_price_o   <= rd_q.high_p;
      low_price_o    <= rd_q.low_p;
      close_price_o  <= rd_q.close_p;
      bar_volume_o   <= rd_q.vol;
      bar_turnover_o <= rd_q.to;
      last_of_run_o  <= ~|(open_q & later_mask);
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // checks
  `OHLC_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `OHLC_ASSERT_NXT(a_busy_after_start, clk_i, rst_ni,
    start_i && !busy_o && func_i && (open_q != '0), busy_o)
  `OHLC_ASSERT_IMP(a_no_out_idle, clk_i, rst_ni,
    bar_valid_o, (state_q == S_WRITE) || (state_q == S_FRD) || (state_q == S_FOUT))
endmodule
